/* rtl/pse_pkg.sv */
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants of the postfix stack evaluator
// stack size, widths, character codes, status codes, operator and state encodings
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

  // operand stack
  localparam int STACK_DEPTH = 16;
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // datapath
  localparam int DATA_W = 32;
  localparam int BIT_W  = $clog2(DATA_W);
  localparam int SYM_W  = 8;
  localparam int STAT_W = 3;
  localparam int OUT_W  = ((DATA_W + STAT_W + 7) / 8) * 8;

  // characters
  localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [STAT_W-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDB,
    S_RDA,
    S_LOAD,
    S_RUN,
    S_FIX,
    S_WR,
    S_TOP,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

/* rtl/postfix_stack_evaluator.sv */
// ----------------------------------------------------------------------------
// postfix_stack_evaluator: serial postfix expression evaluator
// one character per input beat, one result beat per expression
// ----------------------------------------------------------------------------
// usage
//   input channel: in_tdata carries one ascii character, in_tlast marks the
//   last character of an expression. digits push, + - * / pop two operands
//   and push the result, anything else is ignored.
//   output channel: one beat per expression, sent after the last character;
//   out_tdata holds the value (0 on error) and the sticky status code.
// sequence
//   digit, ignored character or underflowing operator: handled on accept.
//   operator: accept, two stack reads, operand load, the bit-serial steps
//   of the shared serial add / shift-add multiply / restoring divide unit,
//   the sign fix and one stack write.
//   divide by zero skips the steps and the sign fix.
//   last character: its own work, then a read of the top of stack.
// reset
//   synchronous active-low rst_n empties the stack and clears the status;
//   stack entries themselves are not cleared, no clearing pass is needed.
// stall
//   the result sits in an output register; a stalled receiver holds the
//   block only when a second result is ready before the first is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_stack_evaluator (
  input  wire                          clk,
  input  wire                          rst_n,
  // input channel
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [pse_pkg::SYM_W-1:0]    in_tdata,   // [7:0] symbol
  input  wire                          in_tlast,   // end_of_expr
  // result channel
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [pse_pkg::OUT_W-1:0]    out_tdata   // [31:0] value, [34:32] status, rest 0
);

  localparam int DW = pse_pkg::DATA_W;

  // operand stack
  logic [DW-1:0] mem [pse_pkg::STACK_DEPTH];
  logic [DW-1:0] rd_data_r;
  logic [pse_pkg::IDX_W-1:0] rd_addr;
  logic [pse_pkg::IDX_W-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic          wr_en;

  // control
  pse_pkg::state_t state_r, state_nxt;
  logic [pse_pkg::CNT_W-1:0]  depth_r;
  logic [pse_pkg::STAT_W-1:0] err_r;
  pse_pkg::op_t               op_r;
  logic                       last_r;
  logic [pse_pkg::BIT_W-1:0]  cnt_r;

  // serial unit: x accumulates, y shifts the other operand, z holds the
  // multiplicand or the divisor magnitude
  logic [DW-1:0] x_r, y_r, z_r, b_r, res_r;
  logic          c_r;
  logic          neg_r;

  logic          out_valid_r;
  logic [DW-1:0] out_value_r;
  logic [pse_pkg::STAT_W-1:0] out_status_r;

  // input decode
  logic       accept;
  logic       is_digit, is_op;
  pse_pkg::op_t in_op;
  logic       can_push, can_pop;
  logic       done_go;
  logic [3:0] digit_val;

  assign accept    = in_tvalid && in_tready;
  assign is_digit  = (in_tdata >= pse_pkg::CH_ZERO) && (in_tdata <= pse_pkg::CH_NINE);
  assign digit_val = 4'(in_tdata - pse_pkg::CH_ZERO);
  assign can_push  = depth_r < pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH);
  assign can_pop   = depth_r >= pse_pkg::CNT_W'(2);

  always_comb begin
    is_op = 1'b1;
    in_op = pse_pkg::OP_ADD;
    priority if (in_tdata == pse_pkg::CH_PLUS) begin
      in_op = pse_pkg::OP_ADD;
    end else if (in_tdata == pse_pkg::CH_MINUS) begin
      in_op = pse_pkg::OP_SUB;
    end else if (in_tdata == pse_pkg::CH_STAR) begin
      in_op = pse_pkg::OP_MUL;
    end else if (in_tdata == pse_pkg::CH_SLASH) begin
      in_op = pse_pkg::OP_DIV;
    end else begin
      is_op = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pse_pkg::S_IDLE: begin
        if (accept) begin
          if (is_op && can_pop) state_nxt = pse_pkg::S_RDB;
          else if (in_tlast)    state_nxt = pse_pkg::S_TOP;
        end
      end
      pse_pkg::S_RDB:  state_nxt = pse_pkg::S_RDA;
      pse_pkg::S_RDA:  state_nxt = pse_pkg::S_LOAD;
      pse_pkg::S_LOAD: begin
        if (op_r == pse_pkg::OP_DIV && b_r == '0) state_nxt = pse_pkg::S_WR;
        else                                      state_nxt = pse_pkg::S_RUN;
      end
      pse_pkg::S_RUN: begin
        if (cnt_r == pse_pkg::BIT_W'(DW - 1)) state_nxt = pse_pkg::S_FIX;
      end
      pse_pkg::S_FIX:  state_nxt = pse_pkg::S_WR;
      pse_pkg::S_WR:   state_nxt = last_r ? pse_pkg::S_TOP : pse_pkg::S_IDLE;
      pse_pkg::S_TOP:  state_nxt = pse_pkg::S_DONE;
      pse_pkg::S_DONE: begin
        if (done_go) state_nxt = pse_pkg::S_IDLE;
      end
      default:         state_nxt = pse_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and stack port control
  always_comb begin
    in_tready = 1'b0;
    done_go   = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = depth_r[pse_pkg::IDX_W-1:0];
    wr_data   = {{(DW-4){1'b0}}, digit_val};
    rd_addr   = pse_pkg::IDX_W'(depth_r - pse_pkg::CNT_W'(1));
    unique case (state_r)
      pse_pkg::S_IDLE: begin
        in_tready = 1'b1;
        wr_en     = in_tvalid && is_digit && can_push;
      end
      pse_pkg::S_RDA: begin
        rd_addr = pse_pkg::IDX_W'(depth_r - pse_pkg::CNT_W'(2));
      end
      pse_pkg::S_WR: begin
        wr_en   = 1'b1;
        wr_addr = pse_pkg::IDX_W'(depth_r - pse_pkg::CNT_W'(2));
        wr_data = res_r;
      end
      pse_pkg::S_DONE: begin
        done_go = !out_valid_r || out_tready;
      end
      default: ;
    endcase
  end

  // stack memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pse_pkg::S_IDLE;
      depth_r <= '0;
      err_r   <= pse_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        pse_pkg::S_IDLE: begin
          if (accept) begin
            if (is_digit) begin
              if (can_push)                  depth_r <= depth_r + pse_pkg::CNT_W'(1);
              else if (err_r == pse_pkg::ST_OK) err_r <= pse_pkg::ST_OVERFLOW;
            end else if (is_op && !can_pop && err_r == pse_pkg::ST_OK) begin
              err_r <= pse_pkg::ST_UNDERFLOW;
            end
          end
        end
        pse_pkg::S_LOAD: begin
          if (op_r == pse_pkg::OP_DIV && b_r == '0 && err_r == pse_pkg::ST_OK)
            err_r <= pse_pkg::ST_DIVZERO;
        end
        pse_pkg::S_WR: depth_r <= depth_r - pse_pkg::CNT_W'(1);
        pse_pkg::S_DONE: begin
          if (done_go) begin
            depth_r <= '0;
            err_r   <= pse_pkg::ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  // serial arithmetic unit
  logic [DW-1:0] a_in, a_mag, b_mag;
  logic [DW:0]   trial;
  logic          sum_bit, carry_nxt;

  assign a_in      = rd_data_r;
  assign a_mag     = a_in[DW-1] ? (DW'(0) - a_in) : a_in;
  assign b_mag     = b_r[DW-1] ? (DW'(0) - b_r) : b_r;
  assign sum_bit   = x_r[0] ^ y_r[0] ^ c_r;
  assign carry_nxt = (x_r[0] & y_r[0]) | (x_r[0] & c_r) | (y_r[0] & c_r);
  assign trial     = {x_r, y_r[DW-1]} - {1'b0, z_r};

  always_ff @(posedge clk) begin
    unique case (state_r)
      pse_pkg::S_IDLE: begin
        if (accept) begin
          op_r   <= in_op;
          last_r <= in_tlast;
        end
      end
      pse_pkg::S_RDA: b_r <= rd_data_r;
      pse_pkg::S_LOAD: begin
        cnt_r <= '0;
        res_r <= '0;
        unique case (op_r)
          pse_pkg::OP_ADD: begin
            x_r <= a_in;
            y_r <= b_r;
            c_r <= 1'b0;
          end
          pse_pkg::OP_SUB: begin
            x_r <= a_in;
            y_r <= ~b_r;
            c_r <= 1'b1;
          end
          pse_pkg::OP_MUL: begin
            x_r <= '0;
            y_r <= b_r;
            z_r <= a_in;
          end
          pse_pkg::OP_DIV: begin
            x_r   <= '0;
            y_r   <= a_mag;
            z_r   <= b_mag;
            neg_r <= a_in[DW-1] ^ b_r[DW-1];
          end
          default: ;
        endcase
      end
      pse_pkg::S_RUN: begin
        cnt_r <= cnt_r + pse_pkg::BIT_W'(1);
        unique case (op_r)
          pse_pkg::OP_ADD, pse_pkg::OP_SUB: begin
            // lsb first, sum bits enter at the top of x
            x_r <= {sum_bit, x_r[DW-1:1]};
            y_r <= {1'b0, y_r[DW-1:1]};
            c_r <= carry_nxt;
          end
          pse_pkg::OP_MUL: begin
            // msb first shift-add
            x_r <= {x_r[DW-2:0], 1'b0} + (y_r[DW-1] ? z_r : '0);
            y_r <= {y_r[DW-2:0], 1'b0};
          end
          pse_pkg::OP_DIV: begin
            // restoring step, quotient bits enter y from the bottom
            if (!trial[DW]) begin
              x_r <= trial[DW-1:0];
              y_r <= {y_r[DW-2:0], 1'b1};
            end else begin
              x_r <= {x_r[DW-2:0], y_r[DW-1]};
              y_r <= {y_r[DW-2:0], 1'b0};
            end
          end
          default: ;
        endcase
      end
      pse_pkg::S_FIX: begin
        if (op_r == pse_pkg::OP_DIV) res_r <= neg_r ? (DW'(0) - y_r) : y_r;
        else                         res_r <= x_r;
      end
      default: ;
    endcase
  end

  // result register
  logic [pse_pkg::STAT_W-1:0] fin_status;

  assign fin_status = (err_r == pse_pkg::ST_OK && depth_r == '0) ? pse_pkg::ST_EMPTY : err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_status_r <= fin_status;
      out_value_r  <= (fin_status == pse_pkg::ST_OK) ? rd_data_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(pse_pkg::OUT_W - DW - pse_pkg::STAT_W){1'b0}},
                       out_status_r, out_value_r};

endmodule

`default_nettype wire
